[design/gfd_pkg.sv]
package gfd_pkg;

   localparam int unsigned LOCK_SYMBOLS = 24;
   localparam int unsigned CONTRAST_MIN = 19660;
   localparam int unsigned COUNT_MAX    = 255;
   localparam logic [15:0] PERIOD_MIN   = 16'd512;
   localparam logic [15:0] PERIOD_RESET = 16'd7680;

   localparam logic [2:0] CSR_MODE   = 3'd0;
   localparam logic [2:0] CSR_COEF0  = 3'd1;
   localparam logic [2:0] CSR_COEF1  = 3'd2;
   localparam logic [2:0] CSR_COEF2  = 3'd3;
   localparam logic [2:0] CSR_COEF3  = 3'd4;
   localparam logic [2:0] CSR_PERIOD = 3'd5;

   typedef logic signed [17:0] coef_type;
   typedef logic signed [39:0] bank_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] quo;
   } div_rsp_type;

   function automatic bank_type sat40(input logic signed [43:0] x);
      if (x > 44'sd549755813887) begin
         return 40'sh7FFFFFFFFF;
      end else if (x < -44'sd549755813888) begin
         return 40'sh8000000000;
      end
      return x[39:0];
   endfunction

   function automatic logic signed [30:0] sat31(input bank_type x);
      if (x > 40'sd1073741823) begin
         return 31'sh3FFFFFFF;
      end else if (x < -40'sd1073741824) begin
         return 31'sh40000000;
      end
      return x[30:0];
   endfunction

endpackage

[design/gfd_bank_mem.sv]
module gfd_bank_mem #(
   parameter int DEPTH = 12,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [79:0]   rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [79:0]   wr_data
);
   import gfd_pkg::*;

   logic [79:0]      mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [79:0]      q_ff;
   logic             qv_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         qv_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            qv_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = qv_ff ? q_ff : '0;

endmodule

[design/gfd_div.sv]
module gfd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  gfd_pkg::div_req_type req,
   output gfd_pkg::div_rsp_type rsp
);
   import gfd_pkg::*;

   typedef enum logic [1:0] {D_IDLE, D_NORM, D_STEP} dstate_type;

   dstate_type  state_ff;
   logic [63:0] num_ff;
   logic [63:0] den_ff;
   logic [47:0] rem_ff;
   logic [16:0] quo_ff;
   logic [4:0]  cnt_ff;
   logic        done_ff;
   logic [47:0] diff;

   assign diff = rem_ff - den_ff[47:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (req.start) begin
                  num_ff   <= req.num;
                  den_ff   <= req.den;
                  state_ff <= D_NORM;
               end
            end
            D_NORM: begin
               if (den_ff[63:46] != '0) begin
                  num_ff <= num_ff >> 1;
                  den_ff <= den_ff >> 1;
               end else begin
                  rem_ff   <= num_ff[47:0];
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= D_STEP;
               end
            end
            D_STEP: begin
               if (rem_ff >= den_ff[47:0]) begin
                  rem_ff <= {diff[46:0], 1'b0};
                  quo_ff <= {quo_ff[15:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[46:0], 1'b0};
                  quo_ff <= {quo_ff[15:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd16) begin
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

[design/goertzel_fsk_demod_multiphase.sv]
// channel  dir  signals                            word
// req      in   req_tvalid/req_tready/req_tdata    [15:0] sample
// rsp      out  rsp_tvalid/rsp_tready/rsp_tdata    [1:0] symbol, [2] locked, [4:3] chosen_phase
// csr      in   csr_we/csr_addr/csr_wdata          register write, no read-back
// One sample at a time through a bank RAM sequencer: an active phase reads, multiplies and
// updates the bank entry of each used tone and reads each unused one; a locked-out phase is
// skipped. A symbol end adds the power states S_PW1 to S_PW5 per used tone, a divide (up to
// 18 normalize shifts) and, before lock, possibly a lock search over the PHASE_COUNT phases.
// Synchronous reset; bank RAM entries read as zero until written (valid bits).
// A result waits in the output register; the next sample is taken meanwhile and stalls
// only if it has another result while the first is still held.
module goertzel_fsk_demod_multiphase #(
   parameter int PHASE_COUNT = 3,
   parameter int TONE_COUNT  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] symbol, [2] locked, [4:3] chosen_phase
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [17:0] csr_wdata
);
   import gfd_pkg::*;

   localparam int PW    = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
   localparam int TW    = $clog2(TONE_COUNT);
   localparam int DEPTH = PHASE_COUNT * TONE_COUNT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [32:0] PH_RECIP =
      33'(((64'd1 << 32) + 64'(PHASE_COUNT) - 64'd1) / 64'(PHASE_COUNT));

   typedef enum logic [3:0] {
      S_IDLE, S_PHASE, S_RD, S_MUL, S_UPD, S_PW1, S_PW2, S_PW3, S_PW4, S_PW5,
      S_DIVGO, S_DIVW, S_EVAL, S_PICK, S_NEXTP, S_OUT
   } state_type;

   // floor(x / PHASE_COUNT) by reciprocal multiplication, x below 2^19
   function automatic logic [15:0] phase_offset(input logic [18:0] x);
      logic [51:0] y;
      y = 52'(x) * 52'(PH_RECIP);
      return y[47:32];
   endfunction

   state_type          state_ff;
   logic               mode_ff;
   coef_type           coef_ff [4];
   logic [15:0]        period_ff;
   logic [15:0]        tc_ff [PHASE_COUNT];
   logic [23:0]        ctot_ff [PHASE_COUNT];
   logic [7:0]         ccnt_ff [PHASE_COUNT];
   logic               lock_ff;
   logic [PW-1:0]      sel_ff;
   logic signed [15:0] sample_ff;
   logic [PW-1:0]      p_ff;
   logic [TW-1:0]      t_ff;
   logic               end_ff;
   logic               emitted_ff;
   logic               pend_ff;
   logic [1:0]         pend_sym_ff;
   logic               pend_lock_ff;
   logic [1:0]         pend_ph_ff;
   bank_type           first_ff;
   bank_type           second_ff;
   logic signed [57:0] prod_ff;
   logic signed [30:0] a_ff;
   logic signed [30:0] b_ff;
   logic signed [65:0] acc_ff;
   logic signed [48:0] ca_ff;
   logic signed [65:0] bm_ff;
   logic [63:0]        best_ff;
   logic [TW-1:0]      bidx_ff;
   logic [63:0]        total_ff;
   logic [PW-1:0]      q_ff;
   logic [PW-1:0]      pbest_ff;
   logic [23:0]        bsum_ff;
   logic [7:0]         bcnt_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_data_ff;

   logic [15:0]        per_eff;
   logic [15:0]        per_new;
   coef_type           coef_sel;
   logic               tone_used;
   logic               last_tone;
   logic               last_phase;
   logic [16:0]        cnt17;
   logic               sym_end;
   logic signed [42:0] m_upd;
   bank_type           s0_sat;
   logic signed [33:0] m_pw;
   logic signed [65:0] v_raw;
   logic [63:0]        v_pw;
   logic               cupd;
   logic [7:0]         cnt0_new;
   logic [31:0]        lhs;
   logic [31:0]        rhs;
   logic               pick_win;
   logic               out_load;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_addr;
   logic [79:0]        mem_rd_data;
   logic               mem_wr_en;
   logic [79:0]        mem_wr_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign per_eff    = (period_ff < PERIOD_MIN) ? PERIOD_MIN : period_ff;
   assign per_new    = (csr_wdata[15:0] < PERIOD_MIN) ? PERIOD_MIN : csr_wdata[15:0];
   assign coef_sel   = coef_ff[2'(t_ff)];
   assign tone_used  = mode_ff || (32'(t_ff) < 32'd2);
   assign last_tone  = (32'(t_ff) == TONE_COUNT - 1);
   assign last_phase = (32'(p_ff) == PHASE_COUNT - 1);
   assign cnt17      = {1'b0, tc_ff[p_ff]} + 17'd256;
   assign sym_end    = (cnt17 >= {1'b0, per_eff});

   assign m_upd  = 43'((prod_ff + 58'sd32768) >>> 16);
   assign s0_sat = sat40(44'(sample_ff) + 44'(m_upd) - 44'(second_ff));
   assign m_pw   = 34'((ca_ff + 49'sd32768) >>> 16);
   assign v_raw  = acc_ff - bm_ff;
   always_comb begin
      if (v_raw < 66'sd0) begin
         v_pw = '0;
      end else if (v_raw > 66'sh3FFFFFFFFFFFFFFF) begin
         v_pw = 64'h3FFFFFFFFFFFFFFF;
      end else begin
         v_pw = v_raw[63:0];
      end
   end

   assign cupd     = (div_rsp.quo > 17'(CONTRAST_MIN)) && (ccnt_ff[p_ff] < 8'(COUNT_MAX));
   assign cnt0_new = ((p_ff == '0) && cupd) ? ccnt_ff[0] + 8'd1 : ccnt_ff[0];
   assign lhs      = 32'(ctot_ff[q_ff]) * 32'(bcnt_ff);
   assign rhs      = 32'(bsum_ff) * 32'(ccnt_ff[q_ff]);
   assign pick_win = (ccnt_ff[q_ff] != 8'd0) && (lhs > rhs);
   assign out_load = (state_ff == S_OUT) && pend_ff && (!rsp_valid_ff || rsp_tready);

   assign mem_rd_en   = (state_ff == S_RD);
   assign mem_addr    = AW'(32'(p_ff) * TONE_COUNT + 32'(t_ff));
   assign mem_wr_en   = ((state_ff == S_MUL) && !tone_used && end_ff) || (state_ff == S_UPD);
   assign mem_wr_data = ((state_ff == S_UPD) && !end_ff) ? {s0_sat, first_ff} : '0;

   assign div_req.start = (state_ff == S_DIVGO);
   assign div_req.num   = best_ff;
   assign div_req.den   = total_ff + 64'd1;

   gfd_bank_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data)
   );

   gfd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= 1'b0;
         period_ff    <= PERIOD_RESET;
         lock_ff      <= 1'b0;
         sel_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            coef_ff[i] <= '0;
         end
         for (int p = 0; p < PHASE_COUNT; p++) begin
            tc_ff[p]   <= 16'((19'(p) * 19'(PERIOD_RESET)) / 19'(PHASE_COUNT));
            ctot_ff[p] <= '0;
            ccnt_ff[p] <= '0;
         end
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_MODE:   mode_ff    <= csr_wdata[0];
               CSR_COEF0:  coef_ff[0] <= csr_wdata;
               CSR_COEF1:  coef_ff[1] <= csr_wdata;
               CSR_COEF2:  coef_ff[2] <= csr_wdata;
               CSR_COEF3:  coef_ff[3] <= csr_wdata;
               CSR_PERIOD: begin
                  period_ff <= csr_wdata[15:0];
                  for (int p = 0; p < PHASE_COUNT; p++) begin
                     tc_ff[p] <= phase_offset(19'(p) * 19'(per_new));
                  end
               end
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  sample_ff  <= req_tdata;
                  p_ff       <= '0;
                  emitted_ff <= 1'b0;
                  pend_ff    <= 1'b0;
                  state_ff   <= S_PHASE;
               end
            end
            S_PHASE: begin
               if (lock_ff && (p_ff != sel_ff)) begin
                  state_ff <= S_NEXTP;
               end else begin
                  end_ff      <= sym_end;
                  tc_ff[p_ff] <= sym_end ? 16'(cnt17 - {1'b0, per_eff}) : cnt17[15:0];
                  t_ff        <= '0;
                  best_ff     <= '0;
                  bidx_ff     <= '0;
                  total_ff    <= '0;
                  state_ff    <= S_RD;
               end
            end
            S_RD: state_ff <= S_MUL;
            S_MUL: begin
               first_ff  <= mem_rd_data[79:40];
               second_ff <= mem_rd_data[39:0];
               prod_ff   <= 58'(coef_sel * $signed(mem_rd_data[79:40]));
               if (tone_used) begin
                  state_ff <= S_UPD;
               end else if (last_tone) begin
                  state_ff <= end_ff ? S_DIVGO : S_NEXTP;
               end else begin
                  t_ff     <= t_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_UPD: begin
               a_ff <= sat31(s0_sat);
               b_ff <= sat31(first_ff);
               if (end_ff) begin
                  state_ff <= S_PW1;
               end else if (last_tone) begin
                  state_ff <= S_NEXTP;
               end else begin
                  t_ff     <= t_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_PW1: begin
               acc_ff   <= 66'(a_ff * a_ff);
               state_ff <= S_PW2;
            end
            S_PW2: begin
               acc_ff   <= acc_ff + 66'(b_ff * b_ff);
               state_ff <= S_PW3;
            end
            S_PW3: begin
               ca_ff    <= 49'(coef_sel * a_ff);
               state_ff <= S_PW4;
            end
            S_PW4: begin
               bm_ff    <= 66'(b_ff * m_pw);
               state_ff <= S_PW5;
            end
            S_PW5: begin
               total_ff <= total_ff + v_pw;
               if ((t_ff == '0) || (v_pw > best_ff)) begin
                  best_ff <= v_pw;
                  bidx_ff <= t_ff;
               end
               if (last_tone) begin
                  state_ff <= S_DIVGO;
               end else begin
                  t_ff     <= t_ff + 1'b1;
                  state_ff <= S_RD;
               end
            end
            S_DIVGO: state_ff <= S_DIVW;
            S_DIVW: begin
               if (div_rsp.done) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (cupd) begin
                  ctot_ff[p_ff] <= ctot_ff[p_ff] + 24'(div_rsp.quo);
                  ccnt_ff[p_ff] <= ccnt_ff[p_ff] + 8'd1;
               end
               if ((p_ff == sel_ff) && !emitted_ff) begin
                  emitted_ff   <= 1'b1;
                  pend_ff      <= 1'b1;
                  pend_sym_ff  <= 2'(bidx_ff);
                  pend_lock_ff <= lock_ff;
                  pend_ph_ff   <= 2'(p_ff);
               end
               if (!lock_ff && (cnt0_new >= 8'(LOCK_SYMBOLS))) begin
                  q_ff     <= '0;
                  pbest_ff <= '0;
                  bsum_ff  <= '0;
                  bcnt_ff  <= 8'd1;
                  state_ff <= S_PICK;
               end else begin
                  state_ff <= S_NEXTP;
               end
            end
            S_PICK: begin
               if (pick_win) begin
                  pbest_ff <= q_ff;
                  bsum_ff  <= ctot_ff[q_ff];
                  bcnt_ff  <= ccnt_ff[q_ff];
               end
               if (32'(q_ff) == PHASE_COUNT - 1) begin
                  sel_ff   <= pick_win ? q_ff : pbest_ff;
                  lock_ff  <= 1'b1;
                  state_ff <= S_NEXTP;
               end else begin
                  q_ff <= q_ff + 1'b1;
               end
            end
            S_NEXTP: begin
               if (last_phase) begin
                  state_ff <= S_OUT;
               end else begin
                  p_ff     <= p_ff + 1'b1;
                  state_ff <= S_PHASE;
               end
            end
            S_OUT: begin
               if (!pend_ff) begin
                  state_ff <= S_IDLE;
               end else if (out_load) begin
                  rsp_data_ff  <= {3'b000, pend_ph_ff, pend_lock_ff, pend_sym_ff};
                  pend_ff      <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[design/gfd_checker.sv]
module gfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);
   logic       seen_ff;
   logic [1:0] seen_ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && rsp_tdata[2]) begin
         seen_ff    <= 1'b1;
         seen_ph_ff <= rsp_tdata[4:3];
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   a_one_sample: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second sample taken while busy");

   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      seen_ff && rsp_tvalid |-> rsp_tdata[2] && (rsp_tdata[4:3] == seen_ph_ff))
      else $error("lock lost or locked phase changed");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:5] == 3'b000)
      else $error("rsp pad bits set");

endmodule

bind goertzel_fsk_demod_multiphase gfd_checker u_gfd_checker (.*);
